@@ rtl/core/rrts_pkg.sv @@
// Shared types and constants of the round-robin task scheduler.
`timescale 1ns / 1ps
`default_nettype none

package rrts_pkg;

   localparam logic [2:0] REQ_CREATE = 3'd0;
   localparam logic [2:0] REQ_SELECT = 3'd1;
   localparam logic [2:0] REQ_DELAY  = 3'd2;
   localparam logic [2:0] REQ_ENTER  = 3'd3;
   localparam logic [2:0] REQ_EXIT   = 3'd4;
   localparam logic [2:0] REQ_PEND   = 3'd5;

   localparam logic [1:0] TS_READY   = 2'd0;
   localparam logic [1:0] TS_RUNNING = 2'd1;
   localparam logic [1:0] TS_BLOCKED = 2'd2;

   localparam logic [7:0]  NEST_MAX  = 8'd255;
   localparam logic [31:0] SWITCH_ADVANCE = 32'd32;

   typedef enum logic [2:0] {
      OP_CREATE,
      OP_SELECT,
      OP_DELAY,
      OP_ENTER,
      OP_EXIT,
      OP_PEND,
      OP_NONE
   } op_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_SAVE,
      B_SCAN,
      B_PICK,
      B_LOAD,
      B_EXEC,
      B_RESP
   } back_state_type;

   typedef struct packed {
      op_type      op;
      logic [2:0]  task_index;
      logic [1:0]  task_state;
      logic [15:0] time_slice;
      logic [31:0] delay_ticks;
      logic [31:0] stack_addr;
   } job_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic full;
      logic empty;
   } queue_ctrl_type;

endpackage

`default_nettype wire

@@ rtl/core/rrts_front.sv @@
// Front end: accepts requests, decodes them and queues them as jobs.
`timescale 1ns / 1ps
`default_nettype none

module rrts_front #(
   parameter int NUM_TASKS   = 8,
   parameter int STACK_WORDS = 256
) (
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [2:0]    req_type,
   input  wire logic [2:0]    req_task_index,
   input  wire logic [1:0]    req_task_state,
   input  wire logic [15:0]   req_time_slice,
   input  wire logic [31:0]   req_delay_ticks,
   input  wire logic [31:0]   req_stack_addr,
   input  wire logic          queue_full,
   output logic               push,
   output rrts_pkg::job_type  push_job
);

   localparam logic [31:0] STACK_OFFSET = 32'(STACK_WORDS * 4 - 64);

   logic index_ok;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;
   assign index_ok  = 32'(req_task_index) < NUM_TASKS;

   always_comb begin
      push_job.task_index  = req_task_index;
      push_job.task_state  = req_task_state;
      push_job.time_slice  = req_time_slice;
      push_job.delay_ticks = req_delay_ticks;
      push_job.stack_addr  = req_stack_addr;
      push_job.op          = rrts_pkg::OP_NONE;
      unique case (req_type)
         rrts_pkg::REQ_CREATE: begin
            push_job.stack_addr = req_stack_addr + STACK_OFFSET;
            push_job.op = index_ok ? rrts_pkg::OP_CREATE : rrts_pkg::OP_NONE;
         end
         rrts_pkg::REQ_SELECT: push_job.op = rrts_pkg::OP_SELECT;
         rrts_pkg::REQ_DELAY:  push_job.op = rrts_pkg::OP_DELAY;
         rrts_pkg::REQ_ENTER:  push_job.op = rrts_pkg::OP_ENTER;
         rrts_pkg::REQ_EXIT:   push_job.op = rrts_pkg::OP_EXIT;
         rrts_pkg::REQ_PEND:   push_job.op = rrts_pkg::OP_PEND;
         default:              push_job.op = rrts_pkg::OP_NONE;
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/core/rrts_queue.sv @@
// Two-entry job queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module rrts_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rrts_pkg::job_type     push_job,
   output rrts_pkg::job_type          head_job,
   input  wire logic                  push,
   input  wire logic                  pop,
   output logic                       full,
   output logic                       empty
);

   rrts_pkg::job_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full     = count_ff == 2'd2;
   assign empty    = count_ff == 2'd0;
   assign head_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/rrts_back.sv @@
// Back end: runs queued jobs against the task table and drives the result register.
`timescale 1ns / 1ps
`default_nettype none

module rrts_back #(
   parameter int NUM_TASKS = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   input  wire logic [2:0]            csr_start_task,
   input  wire rrts_pkg::job_type     head_job,
   input  wire logic                  queue_empty,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [2:0]                 rsp_current_task,
   output logic [31:0]                rsp_next_stack,
   output logic [15:0]                rsp_time_left,
   output logic [7:0]                 rsp_critical_count,
   output logic                       rsp_pend_trigger
);

   localparam int IW = $clog2(NUM_TASKS);
   localparam logic [IW-1:0] IDLE_TASK = IW'(NUM_TASKS - 1);
   localparam logic [IW-1:0] LAST_SCAN = IW'(NUM_TASKS - 2);
   localparam logic [IW:0]   WORK_TASKS = (IW + 1)'(NUM_TASKS - 1);

   rrts_pkg::back_state_type fsm_ff, fsm_in;
   rrts_pkg::job_type        job_ff, job_in;

   logic [1:0]    state_ff [NUM_TASKS];
   logic [1:0]    state_in [NUM_TASKS];
   logic [31:0]   stack_mem_ff [NUM_TASKS];
   logic [15:0]   slice_mem_ff [NUM_TASKS];
   logic [15:0]   left_mem_ff [NUM_TASKS];
   logic [31:0]   delay_mem_ff [NUM_TASKS];
   logic [NUM_TASKS-1:0] stack_vld_ff, slice_vld_ff, left_vld_ff;

   logic [IW-1:0] cur_ff, cur_in;
   logic [IW-1:0] scan_ff, scan_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic [7:0]    nest_ff, nest_in;
   logic          pend_ff, pend_in;
   logic          trig_ff, trig_in;
   logic [31:0]   res_sp_ff, res_sp_in;
   logic [15:0]   res_left_ff, res_left_in;

   logic          stack_we, slice_we, left_we, delay_we;
   logic [IW-1:0] stack_waddr, slice_waddr, delay_waddr;
   logic [31:0]   stack_wdata;
   logic          pick_re, left_re;
   logic [31:0]   stack_rd_ff;
   logic [15:0]   slice_rd_ff, left_rd_ff;
   logic          stack_rd_vld_ff, slice_rd_vld_ff, left_rd_vld_ff;

   logic [31:0]   picked_sp;
   logic [15:0]   picked_slice;
   logic [IW-1:0] create_idx;
   logic [IW-1:0] scan_next, cur_next;
   logic [7:0]    nest_dec;
   logic          out_load;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_task_ff;
   logic [31:0]   rsp_sp_ff;
   logic [15:0]   rsp_left_ff, rsp_left_in;
   logic [7:0]    rsp_nest_ff;
   logic          rsp_trig_ff;

   function automatic logic [IW-1:0] next_work(input logic [IW-1:0] idx);
      logic [IW:0] n;
      n = {1'b0, idx} + (IW + 1)'(1);
      if (n >= WORK_TASKS) begin
         n = n - WORK_TASKS;
      end
      if (n >= WORK_TASKS) begin
         n = n - WORK_TASKS;
      end
      return n[IW-1:0];
   endfunction

   assign create_idx   = IW'(job_ff.task_index);
   assign scan_next    = next_work(scan_ff);
   assign cur_next     = next_work(cur_ff);
   assign picked_sp    = stack_rd_vld_ff ? stack_rd_ff : 32'd0;
   assign picked_slice = slice_rd_vld_ff ? slice_rd_ff : 16'd0;
   assign nest_dec     = (nest_ff == 8'd0) ? 8'd0 : nest_ff - 8'd1;
   assign out_load     = (fsm_ff == rrts_pkg::B_RESP) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      fsm_in      = fsm_ff;
      job_in      = job_ff;
      state_in    = state_ff;
      cur_in      = cur_ff;
      scan_in     = scan_ff;
      cnt_in      = cnt_ff;
      nest_in     = nest_ff;
      pend_in     = pend_ff;
      trig_in     = trig_ff;
      res_sp_in   = res_sp_ff;
      res_left_in = res_left_ff;
      pop         = 1'b0;
      stack_we    = 1'b0;
      stack_waddr = cur_ff;
      stack_wdata = job_ff.stack_addr;
      slice_we    = 1'b0;
      slice_waddr = create_idx;
      left_we     = 1'b0;
      delay_we    = 1'b0;
      delay_waddr = cur_ff;
      pick_re     = 1'b0;
      left_re     = 1'b0;

      unique case (fsm_ff)
         rrts_pkg::B_IDLE: begin
            if (!queue_empty) begin
               pop       = 1'b1;
               job_in    = head_job;
               trig_in   = 1'b0;
               res_sp_in = 32'd0;
               fsm_in    = (head_job.op == rrts_pkg::OP_SELECT) ? rrts_pkg::B_SAVE
                                                                : rrts_pkg::B_EXEC;
            end
         end
         rrts_pkg::B_SAVE: begin
            stack_we = 1'b1;
            if (state_ff[cur_ff] == rrts_pkg::TS_RUNNING) begin
               state_in[cur_ff] = rrts_pkg::TS_READY;
            end
            scan_in = cur_next;
            cnt_in  = '0;
            fsm_in  = rrts_pkg::B_SCAN;
         end
         rrts_pkg::B_SCAN: begin
            priority if (state_ff[scan_ff] == rrts_pkg::TS_READY) begin
               fsm_in = rrts_pkg::B_PICK;
            end else if (cnt_ff == LAST_SCAN) begin
               scan_in = IDLE_TASK;
               fsm_in  = rrts_pkg::B_PICK;
            end else begin
               scan_in = scan_next;
               cnt_in  = cnt_ff + IW'(1);
            end
         end
         rrts_pkg::B_PICK: begin
            cur_in            = scan_ff;
            state_in[scan_ff] = rrts_pkg::TS_RUNNING;
            pick_re           = 1'b1;
            fsm_in            = rrts_pkg::B_LOAD;
         end
         rrts_pkg::B_LOAD: begin
            left_we     = 1'b1;
            stack_we    = 1'b1;
            stack_waddr = cur_ff;
            stack_wdata = picked_sp + rrts_pkg::SWITCH_ADVANCE;
            res_sp_in   = picked_sp;
            res_left_in = picked_slice;
            fsm_in      = rrts_pkg::B_RESP;
         end
         rrts_pkg::B_EXEC: begin
            left_re = 1'b1;
            unique case (job_ff.op)
               rrts_pkg::OP_CREATE: begin
                  state_in[create_idx] = job_ff.task_state;
                  slice_we    = 1'b1;
                  delay_we    = 1'b1;
                  delay_waddr = create_idx;
                  stack_we    = 1'b1;
                  stack_waddr = create_idx;
               end
               rrts_pkg::OP_DELAY: begin
                  delay_we         = 1'b1;
                  state_in[cur_ff] = rrts_pkg::TS_BLOCKED;
                  trig_in          = 1'b1;
               end
               rrts_pkg::OP_ENTER: begin
                  if (nest_ff != rrts_pkg::NEST_MAX) begin
                     nest_in = nest_ff + 8'd1;
                  end
               end
               rrts_pkg::OP_EXIT: begin
                  nest_in = nest_dec;
                  if (nest_dec == 8'd0 && pend_ff) begin
                     pend_in = 1'b0;
                     trig_in = 1'b1;
                  end
               end
               rrts_pkg::OP_PEND: pend_in = 1'b1;
               default: ;
            endcase
            fsm_in = rrts_pkg::B_RESP;
         end
         rrts_pkg::B_RESP: begin
            if (out_load) begin
               fsm_in = rrts_pkg::B_IDLE;
            end
         end
         default: fsm_in = rrts_pkg::B_IDLE;
      endcase

      if (csr_valid) begin
         cur_in = (32'(csr_start_task) < NUM_TASKS) ? IW'(csr_start_task) : IDLE_TASK;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
      if (job_ff.op == rrts_pkg::OP_SELECT) begin
         rsp_left_in = res_left_ff;
      end else begin
         rsp_left_in = left_rd_vld_ff ? left_rd_ff : 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= rrts_pkg::B_IDLE;
         nest_ff      <= 8'd0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         stack_vld_ff <= '0;
         slice_vld_ff <= '0;
         left_vld_ff  <= '0;
         for (int i = 0; i < NUM_TASKS; i++) begin
            state_ff[i] <= rrts_pkg::TS_READY;
         end
         cur_ff       <= '0;
      end else begin
         fsm_ff       <= fsm_in;
         cur_ff       <= cur_in;
         nest_ff      <= nest_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
         if (stack_we) begin
            stack_vld_ff[stack_waddr] <= 1'b1;
         end
         if (slice_we) begin
            slice_vld_ff[slice_waddr] <= 1'b1;
         end
         if (left_we) begin
            left_vld_ff[cur_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      scan_ff     <= scan_in;
      cnt_ff      <= cnt_in;
      trig_ff     <= trig_in;
      res_sp_ff   <= res_sp_in;
      res_left_ff <= res_left_in;
      if (out_load) begin
         rsp_task_ff <= 3'(cur_ff);
         rsp_sp_ff   <= res_sp_ff;
         rsp_left_ff <= rsp_left_in;
         rsp_nest_ff <= nest_ff;
         rsp_trig_ff <= trig_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem_ff[stack_waddr] <= stack_wdata;
      end
      if (slice_we) begin
         slice_mem_ff[slice_waddr] <= job_ff.time_slice;
      end
      if (left_we) begin
         left_mem_ff[cur_ff] <= picked_slice;
      end
      if (delay_we) begin
         delay_mem_ff[delay_waddr] <= job_ff.delay_ticks;
      end
      if (pick_re) begin
         stack_rd_ff     <= stack_mem_ff[scan_ff];
         stack_rd_vld_ff <= stack_vld_ff[scan_ff];
         slice_rd_ff     <= slice_mem_ff[scan_ff];
         slice_rd_vld_ff <= slice_vld_ff[scan_ff];
      end
      if (left_re) begin
         left_rd_ff     <= left_mem_ff[cur_ff];
         left_rd_vld_ff <= left_vld_ff[cur_ff];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_current_task   = rsp_task_ff;
   assign rsp_next_stack     = rsp_sp_ff;
   assign rsp_time_left      = rsp_left_ff;
   assign rsp_critical_count = rsp_nest_ff;
   assign rsp_pend_trigger   = rsp_trig_ff;

endmodule

`default_nettype wire

@@ rtl/core/round_robin_task_scheduler.sv @@
// Top level of the round-robin task scheduler.
`timescale 1ns / 1ps
`default_nettype none

// The scheduler takes one request per transfer and returns exactly one result per request,
// in order. For a select request the back end saves the running task's stack, then does a
// one-entry-per-cycle scan over the work tasks' states followed by a read of the chosen task's
// stack and slice memories and a write-back of its stack and time-left memories. A two-entry
// queue lets requests be accepted while the back end works, and the result register lets the
// next job run while a finished result waits. The start task write port is always ready and
// is to be used only while the scheduler has no request in flight.
module round_robin_task_scheduler #(
   parameter int NUM_TASKS   = 8,
   parameter int STACK_WORDS = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_start_task,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_type,
   input  wire logic [2:0]  req_task_index,
   input  wire logic [1:0]  req_task_state,
   input  wire logic [15:0] req_time_slice,
   input  wire logic [31:0] req_delay_ticks,
   input  wire logic [31:0] req_stack_addr,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_current_task,
   output logic [31:0]      rsp_next_stack,
   output logic [15:0]      rsp_time_left,
   output logic [7:0]       rsp_critical_count,
   output logic             rsp_pend_trigger
);

   rrts_pkg::job_type        push_job, head_job;
   rrts_pkg::queue_ctrl_type qc;

   assign csr_ready = 1'b1;

   rrts_front #(
      .NUM_TASKS   (NUM_TASKS),
      .STACK_WORDS (STACK_WORDS)
   ) u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_task_index  (req_task_index),
      .req_task_state  (req_task_state),
      .req_time_slice  (req_time_slice),
      .req_delay_ticks (req_delay_ticks),
      .req_stack_addr  (req_stack_addr),
      .queue_full      (qc.full),
      .push            (qc.push),
      .push_job        (push_job)
   );

   rrts_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_job (push_job),
      .head_job (head_job),
      .push     (qc.push),
      .pop      (qc.pop),
      .full     (qc.full),
      .empty    (qc.empty)
   );

   rrts_back #(
      .NUM_TASKS (NUM_TASKS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid && csr_ready),
      .csr_start_task     (csr_start_task),
      .head_job           (head_job),
      .queue_empty        (qc.empty),
      .pop                (qc.pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_current_task   (rsp_current_task),
      .rsp_next_stack     (rsp_next_stack),
      .rsp_time_left      (rsp_time_left),
      .rsp_critical_count (rsp_critical_count),
      .rsp_pend_trigger   (rsp_pend_trigger)
   );

endmodule

`default_nettype wire

@@ tb/sv/sched_checker.sv @@
// Checker for the task scheduler: predicts each result and compares it with the rsp channel.
`timescale 1ns / 1ps

module sched_checker #(
   parameter int NUM_TASKS   = 8,
   parameter int STACK_WORDS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_start_task,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic [2:0]  req_task_index,
   input  logic [1:0]  req_task_state,
   input  logic [15:0] req_time_slice,
   input  logic [31:0] req_delay_ticks,
   input  logic [31:0] req_stack_addr,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_current_task,
   input  logic [31:0] rsp_next_stack,
   input  logic [15:0] rsp_time_left,
   input  logic [7:0]  rsp_critical_count,
   input  logic        rsp_pend_trigger,
   output int          mismatch_count,
   output int          awaiting
);

   typedef struct packed {
      logic [2:0]  task_no;
      logic [31:0] stack;
      logic [15:0] left;
      logic [7:0]  depth;
      logic        trig;
   } sched_result_type;

   logic [1:0]  state_of [NUM_TASKS];
   logic [31:0] stack_of [NUM_TASKS];
   logic [15:0] slice_of [NUM_TASKS];
   logic [15:0] left_of  [NUM_TASKS];
   logic [31:0] ticks_of [NUM_TASKS];
   logic [2:0]  running_task;
   logic [7:0]  nest_depth;
   logic        switch_wanted;

   sched_result_type expected_q[$];

   function automatic logic [2:0] clamp_task(input logic [2:0] idx);
      return (idx < NUM_TASKS) ? idx : 3'(NUM_TASKS - 1);
   endfunction

   function automatic logic [2:0] next_ready(input logic [2:0] from);
      int probe;
      probe = from;
      for (int n = 0; n < NUM_TASKS - 1; n++) begin
         probe = (probe + 1) % (NUM_TASKS - 1);
         if (state_of[probe] == rrts_pkg::TS_READY)
            return 3'(probe);
      end
      return 3'(NUM_TASKS - 1);
   endfunction

   function automatic sched_result_type apply_request(input logic [2:0] kind,
         input logic [2:0] idx, input logic [1:0] st, input logic [15:0] slice,
         input logic [31:0] ticks, input logic [31:0] sp);
      sched_result_type r;
      r = '0;
      case (kind)
         rrts_pkg::REQ_CREATE: begin
            if (idx < NUM_TASKS) begin
               state_of[idx] = st;
               slice_of[idx] = slice;
               ticks_of[idx] = ticks;
               stack_of[idx] = sp + 32'(STACK_WORDS * 4) - 32'd64;
            end
         end
         rrts_pkg::REQ_SELECT: begin
            stack_of[running_task] = sp;
            if (state_of[running_task] == rrts_pkg::TS_RUNNING)
               state_of[running_task] = rrts_pkg::TS_READY;
            running_task = next_ready(running_task);
            state_of[running_task] = rrts_pkg::TS_RUNNING;
            left_of[running_task] = slice_of[running_task];
            r.stack = stack_of[running_task];
            stack_of[running_task] = stack_of[running_task] + 32'd32;
         end
         rrts_pkg::REQ_DELAY: begin
            ticks_of[running_task] = ticks;
            state_of[running_task] = rrts_pkg::TS_BLOCKED;
            r.trig = 1'b1;
         end
         rrts_pkg::REQ_ENTER: begin
            if (nest_depth != rrts_pkg::NEST_MAX)
               nest_depth = nest_depth + 8'd1;
         end
         rrts_pkg::REQ_EXIT: begin
            if (nest_depth != 8'd0)
               nest_depth = nest_depth - 8'd1;
            if (nest_depth == 8'd0 && switch_wanted) begin
               switch_wanted = 1'b0;
               r.trig = 1'b1;
            end
         end
         rrts_pkg::REQ_PEND: switch_wanted = 1'b1;
         default: ;
      endcase
      r.task_no = running_task;
      r.left = left_of[running_task];
      r.depth = nest_depth;
      return r;
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want,
         input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      sched_result_type want;
      if (reset) begin
         for (int i = 0; i < NUM_TASKS; i++) begin
            state_of[i] = '0;
            stack_of[i] = '0;
            slice_of[i] = '0;
            left_of[i] = '0;
            ticks_of[i] = '0;
         end
         running_task = clamp_task(3'd0);
         nest_depth = '0;
         switch_wanted = 1'b0;
         expected_q.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $error("result transfer with no request outstanding");
               mismatch_count++;
            end else begin
               want = expected_q.pop_front();
               compare_field("current_task", want.task_no, rsp_current_task);
               compare_field("next_stack", want.stack, rsp_next_stack);
               compare_field("time_left", want.left, rsp_time_left);
               compare_field("critical_count", want.depth, rsp_critical_count);
               compare_field("pend_trigger", want.trig, rsp_pend_trigger);
            end
         end
         if (csr_valid && csr_ready)
            running_task = clamp_task(csr_start_task);
         if (req_valid && !req_stall)
            expected_q.push_back(apply_request(req_type, req_task_index, req_task_state,
                  req_time_slice, req_delay_ticks, req_stack_addr));
      end
      awaiting = expected_q.size();
   end

endmodule

@@ tb/sv/testbench.sv @@
// Top of the scheduler testbench: clock, reset, request stimulus, result stalls and verdict.
`timescale 1ns / 1ps

module testbench;

   localparam int NUM_TASKS = 8;
   localparam int STACK_WORDS = 256;
   localparam int HOLD_CYCLES = 200;
   localparam logic [2:0] REQ_RSVD6 = 3'd6;
   localparam logic [2:0] REQ_RSVD7 = 3'd7;
   localparam logic [1:0] TS_UNUSED = 2'd3;

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_start_task;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_type;
   logic [2:0]  req_task_index;
   logic [1:0]  req_task_state;
   logic [15:0] req_time_slice;
   logic [31:0] req_delay_ticks;
   logic [31:0] req_stack_addr;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_current_task;
   logic [31:0] rsp_next_stack;
   logic [15:0] rsp_time_left;
   logic [7:0]  rsp_critical_count;
   logic        rsp_pend_trigger;

   int errors;
   int outstanding;
   bit calm;
   bit long_hold;

   round_robin_task_scheduler #(
      .NUM_TASKS(NUM_TASKS),
      .STACK_WORDS(STACK_WORDS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_start_task(csr_start_task),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_task_index(req_task_index),
      .req_task_state(req_task_state),
      .req_time_slice(req_time_slice),
      .req_delay_ticks(req_delay_ticks),
      .req_stack_addr(req_stack_addr),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_current_task(rsp_current_task),
      .rsp_next_stack(rsp_next_stack),
      .rsp_time_left(rsp_time_left),
      .rsp_critical_count(rsp_critical_count),
      .rsp_pend_trigger(rsp_pend_trigger)
   );

   sched_checker #(
      .NUM_TASKS(NUM_TASKS),
      .STACK_WORDS(STACK_WORDS)
   ) u_check (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_start_task(csr_start_task),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_task_index(req_task_index),
      .req_task_state(req_task_state),
      .req_time_slice(req_time_slice),
      .req_delay_ticks(req_delay_ticks),
      .req_stack_addr(req_stack_addr),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_current_task(rsp_current_task),
      .rsp_next_stack(rsp_next_stack),
      .rsp_time_left(rsp_time_left),
      .rsp_critical_count(rsp_critical_count),
      .rsp_pend_trigger(rsp_pend_trigger),
      .mismatch_count(errors),
      .awaiting(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // The result side stalls in short random bursts, and once for a long stretch on request.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            long_hold = 1'b0;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(0, 16)) @(negedge clock);
            @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
            if (!calm)
               repeat ($urandom_range(0, 12)) @(negedge clock);
         end
      end
   end

   task automatic offer(input logic [2:0] kind, input logic [2:0] idx, input logic [1:0] st,
         input logic [15:0] slice, input logic [31:0] ticks, input logic [31:0] sp);
      int gap;
      gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_type <= kind;
      req_task_index <= idx;
      req_task_state <= st;
      req_time_slice <= slice;
      req_delay_ticks <= ticks;
      req_stack_addr <= sp;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic [1:0] pick_state();
      return ($urandom_range(0, 1) == 0) ? rrts_pkg::TS_READY : 2'($urandom_range(0, 3));
   endfunction

   task automatic offer_op(input logic [2:0] kind);
      offer(kind, 3'($urandom_range(0, 7)), pick_state(), 16'($urandom), $urandom, $urandom);
   endtask

   task automatic offer_mixed();
      int roll;
      logic [2:0] kind;
      roll = $urandom_range(0, 99);
      if (roll < 25)
         kind = rrts_pkg::REQ_CREATE;
      else if (roll < 55)
         kind = rrts_pkg::REQ_SELECT;
      else if (roll < 65)
         kind = rrts_pkg::REQ_DELAY;
      else if (roll < 76)
         kind = rrts_pkg::REQ_ENTER;
      else if (roll < 88)
         kind = rrts_pkg::REQ_EXIT;
      else if (roll < 96)
         kind = rrts_pkg::REQ_PEND;
      else
         kind = roll[0] ? REQ_RSVD7 : REQ_RSVD6;
      offer_op(kind);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_start(input logic [2:0] value);
      @(negedge clock);
      csr_start_task <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int count;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_start_task = '0;
      req_valid = 1'b0;
      req_type = rrts_pkg::REQ_CREATE;
      req_task_index = '0;
      req_task_state = rrts_pkg::TS_READY;
      req_time_slice = '0;
      req_delay_ticks = '0;
      req_stack_addr = '0;
      calm = 1'b0;
      long_hold = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Start on the idle task and walk through ready, blocked, all-blocked and idle cases.
      write_start(3'd7);
      offer(rrts_pkg::REQ_CREATE, 3'd0, rrts_pkg::TS_READY, 16'hFFFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF);
      offer(rrts_pkg::REQ_CREATE, 3'd7, TS_UNUSED, 16'h1234, 32'h0, 32'h8000_0000);
      offer(rrts_pkg::REQ_SELECT, 3'd0, rrts_pkg::TS_READY, 16'h0, 32'h0, 32'hAAAA_5555);
      offer(rrts_pkg::REQ_DELAY, 3'd0, rrts_pkg::TS_READY, 16'h0, 32'd5, 32'h0);
      for (int i = 2; i < 7; i++)
         offer(rrts_pkg::REQ_CREATE, 3'(i), rrts_pkg::TS_BLOCKED, 16'(i * 100), 32'(i),
               32'(i << 12));
      offer(rrts_pkg::REQ_SELECT, 3'd7, TS_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 32'h5555_AAAA);
      offer(rrts_pkg::REQ_DELAY, 3'd0, rrts_pkg::TS_READY, 16'h0, 32'hFFFF_FFFF, 32'h0);
      offer(rrts_pkg::REQ_SELECT, 3'd0, rrts_pkg::TS_READY, 16'h0, 32'h0, 32'h0000_1000);
      offer(rrts_pkg::REQ_SELECT, 3'd0, rrts_pkg::TS_READY, 16'h0, 32'h0, 32'hFFFF_FFF0);
      offer(rrts_pkg::REQ_CREATE, 3'd3, rrts_pkg::TS_RUNNING, 16'h0042, 32'h0, 32'h0000_2000);
      offer(rrts_pkg::REQ_SELECT, 3'd0, rrts_pkg::TS_READY, 16'h0, 32'h0, 32'h0000_3000);
      offer(rrts_pkg::REQ_ENTER, 3'd0, rrts_pkg::TS_READY, 16'h0, 32'h0, 32'h0);
      offer(rrts_pkg::REQ_PEND, 3'd0, rrts_pkg::TS_READY, 16'h0, 32'h0, 32'h0);
      offer(rrts_pkg::REQ_EXIT, 3'd0, rrts_pkg::TS_READY, 16'h0, 32'h0, 32'h0);
      offer(rrts_pkg::REQ_EXIT, 3'd0, rrts_pkg::TS_READY, 16'h0, 32'h0, 32'h0);
      offer(rrts_pkg::REQ_PEND, 3'd0, rrts_pkg::TS_READY, 16'h0, 32'h0, 32'h0);
      offer(rrts_pkg::REQ_EXIT, 3'd0, rrts_pkg::TS_READY, 16'h0, 32'h0, 32'h0);
      offer(REQ_RSVD6, 3'd7, TS_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      offer(REQ_RSVD7, 3'd5, rrts_pkg::TS_BLOCKED, 16'h5A5A, 32'h1234_5678, 32'h8765_4321);
      offer(rrts_pkg::REQ_CREATE, 3'd5, rrts_pkg::TS_READY, 16'h0, 32'h0, 32'h0);
      offer(rrts_pkg::REQ_SELECT, 3'd0, rrts_pkg::TS_READY, 16'h0, 32'h0, 32'hDEAD_0000);
      settle();

      // Drive the nesting depth into saturation and back down with the pending flag in play.
      write_start(3'd0);
      count = 0;
      while (count < 260) begin
         if ($urandom_range(0, 4) != 0) begin
            offer_op(rrts_pkg::REQ_ENTER);
            count++;
         end else begin
            case ($urandom_range(0, 3))
               0: offer_op(rrts_pkg::REQ_CREATE);
               1: offer_op(rrts_pkg::REQ_SELECT);
               2: offer_op(rrts_pkg::REQ_PEND);
               default: offer_op(rrts_pkg::REQ_DELAY);
            endcase
         end
      end
      count = 0;
      while (count < 262) begin
         if ($urandom_range(0, 4) != 0) begin
            offer_op(rrts_pkg::REQ_EXIT);
            count++;
         end else begin
            case ($urandom_range(0, 2))
               0: offer_op(rrts_pkg::REQ_PEND);
               1: offer_op(rrts_pkg::REQ_SELECT);
               default: offer_op(rrts_pkg::REQ_CREATE);
            endcase
         end
      end
      settle();

      write_start(3'($urandom_range(1, 6)));
      for (int i = 0; i < 170; i++) begin
         if (i == 60)
            long_hold = 1'b1;
         offer_mixed();
      end
      settle();

      write_start(3'($urandom_range(0, 7)));
      for (int i = 0; i < 130; i++) begin
         if (i == 40)
            calm = 1'b1;
         offer_mixed();
      end
      settle();
      repeat (20) @(negedge clock);

      if (errors == 0 && outstanding == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
